// ===== sv/rsps_pkg.sv =====
// ----------------------------------------------------------------------------
// rsps_pkg: shared types and constants of the range scan segmenter
// Config record, queue item, register indexes and the sine table generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsps_pkg;

    localparam int MAX_POINTS_DEF  = 4096;
    localparam int SINE_BITS_DEF   = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [11:0] SEG_MAX   = 12'd4095;
    // kr * 2*pi in Q16
    localparam logic [21:0] KR_TWO_PI = 22'd4117750;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
    localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
    localparam logic [2:0] REG_ANGLE_MIN  = 3'd2;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd3;
    localparam logic [2:0] REG_ROW_X      = 3'd4;
    localparam logic [2:0] REG_ROW_Y      = 3'd5;
    localparam logic [2:0] REG_OFFSET_X   = 3'd6;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd7;

    typedef struct packed {
        logic [19:0]        range_min;
        logic [19:0]        range_max;
        logic [15:0]        angle_min;
        logic [15:0]        angle_step;
        logic [63:0]        row_x;
        logic [63:0]        row_y;
        logic signed [20:0] off_x;
        logic signed [20:0] off_y;
    } t_cfg;

    typedef struct packed {
        logic        pvalid;
        logic [19:0] range;
        logic [15:0] az;
        logic        sstart;
        logic [11:0] pidx;
        logic [11:0] sidx;
        logic        last;
        logic [12:0] total;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // sin(j/Q of a quarter turn) in Q1.14, Q = 2^(bits-2), nine-term Taylor sum in Q30
    function automatic logic [14:0] quarter_sine(input int unsigned j, input int unsigned bits);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint unsigned rnd;
        x    = (64'(j) * HALF_PI_Q30) >> (bits - 2);
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (64'(sum) + 64'd32768) >> 16;
        return rnd[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/rsps_if.sv =====
// ----------------------------------------------------------------------------
// rsps channel interfaces
// Sample input, point result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsps_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] range_mm;
    logic        range_bad;
    logic        scan_last;
    modport source (output valid, range_mm, range_bad, scan_last, input ready);
    modport sink   (input valid, range_mm, range_bad, scan_last, output ready);
endinterface

interface rsps_out_if;
    logic               valid;
    logic               ready;
    logic               point_valid;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [11:0]        point_index;
    logic               segment_start;
    logic [11:0]        segment_index;
    logic               scan_done;
    logic [12:0]        point_total;
    modport source (output valid, point_valid, point_x, point_y, point_index,
                    segment_start, segment_index, scan_done, point_total, input ready);
    modport sink   (input valid, point_valid, point_x, point_y, point_index,
                    segment_start, segment_index, scan_done, point_total, output ready);
endinterface

interface rsps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/rsps_front.sv =====
// ----------------------------------------------------------------------------
// rsps_front: sample intake and classification
// Range checks, jump test, point and segment counting, scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_front import rsps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rsps_in_if.sink i_in,
    input  t_cfg    i_cfg,
    input  t_q_stat i_qst,
    output logic    o_push,
    output t_item   o_item
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_DEC  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [19:0]      r_range;
    logic             r_bad;
    logic             r_last;
    logic [15:0]      r_az_off, n_az_off;
    logic [19:0]      r_prev, n_prev;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [11:0]      r_seg, n_seg;
    logic             r_any, n_any;
    logic [37:0]      r_kstep;
    logic [38:0]      r_p_lo;
    logic [38:0]      r_p_hi;

    logic [15:0]       w_ast;
    logic [57:0]       w_prod;
    logic [25:0]       w_thr;
    logic [19:0]       w_diff;
    logic              w_valid;
    logic              w_jump;
    logic [CNT_W+12:0] w_cnt_old;
    logic [CNT_W+12:0] w_cnt_new;

    assign w_ast = i_cfg.angle_step[15] ? 16'(-i_cfg.angle_step) : i_cfg.angle_step;
    assign i_in.ready = (r_state == F_IDLE);

    // threshold = (r * |step| * kr * 2pi) >> 32, assembled from two partial products
    assign w_prod  = {r_p_hi, 19'b0} + {19'b0, r_p_lo};
    assign w_thr   = w_prod[57:32];
    assign w_diff  = (r_range >= r_prev) ? (r_range - r_prev) : (r_prev - r_range);
    assign w_valid = !r_bad && (r_range > i_cfg.range_min) && (r_range < i_cfg.range_max)
                     && (r_cnt < CNT_MAX);
    assign w_jump  = w_valid && ({6'b0, w_diff} > w_thr);
    assign o_push  = (r_state == F_DEC) && !i_qst.full;

    always_comb begin
        n_state  = r_state;
        n_az_off = r_az_off;
        n_prev   = r_prev;
        n_cnt    = r_cnt;
        n_seg    = r_seg;
        n_any    = r_any;
        unique case (r_state)
            F_IDLE: begin
                if (i_in.valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_DEC;
            end
            F_DEC: begin
                if (o_push) begin
                    n_state = F_IDLE;
                    if (w_jump) begin
                        if (r_any) begin
                            if (r_seg < SEG_MAX) begin
                                n_seg = r_seg + 12'd1;
                            end
                        end else begin
                            n_any = 1'b1;
                        end
                    end
                    if (w_valid) begin
                        n_cnt  = r_cnt + CNT_W'(1);
                        n_prev = r_range;
                    end else begin
                        n_prev = 20'd0;
                    end
                    n_az_off = r_az_off + i_cfg.angle_step;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign w_cnt_old = {13'b0, r_cnt};
    assign w_cnt_new = {13'b0, n_cnt};

    always_comb begin
        o_item.pvalid = w_valid;
        o_item.range  = r_range;
        o_item.az     = i_cfg.angle_min + r_az_off;
        o_item.sstart = w_jump;
        o_item.pidx   = w_valid ? w_cnt_old[11:0] : 12'd0;
        o_item.sidx   = (w_valid && n_any) ? n_seg : 12'd0;
        o_item.last   = r_last;
        o_item.total  = w_cnt_new[12:0];
    end

    always_ff @(posedge i_clk) begin
        r_kstep <= 38'(w_ast) * 38'(KR_TWO_PI);
        if (r_state == F_IDLE && i_in.valid) begin
            r_range <= i_in.range_mm;
            r_bad   <= i_in.range_bad;
            r_last  <= i_in.scan_last;
        end
        if (r_state == F_MUL) begin
            r_p_lo <= 39'(r_range) * 39'(r_kstep[18:0]);
            r_p_hi <= 39'(r_range) * 39'(r_kstep[37:19]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_az_off <= 16'd0;
            r_prev   <= 20'd0;
            r_cnt    <= '0;
            r_seg    <= 12'd0;
            r_any    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_push && r_last) begin
                r_az_off <= 16'd0;
                r_prev   <= 20'd0;
                r_cnt    <= '0;
                r_seg    <= 12'd0;
                r_any    <= 1'b0;
            end else begin
                r_az_off <= n_az_off;
                r_prev   <= n_prev;
                r_cnt    <= n_cnt;
                r_seg    <= n_seg;
                r_any    <= n_any;
            end
        end
    end

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_last) |=> (r_cnt == '0 && r_az_off == 16'd0 && !r_any))
        else $error("scan state not cleared after last sample");

    a_seg_before_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_any |-> (r_seg == 12'd0))
        else $error("segment count moved before first jump");

endmodule

`default_nettype wire

// ===== sv/rsps_queue.sv =====
// ----------------------------------------------------------------------------
// rsps_queue: small FIFO between intake and arithmetic pipeline
// Show-ahead read, full and empty status.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_queue import rsps_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ===== sv/rsps_back.sv =====
// ----------------------------------------------------------------------------
// rsps_back: trig, mounting transform and saturation pipeline
// Five stages: table lookup, polar scale, matrix products, round, offset.
// ----------------------------------------------------------------------------
`default_nettype none

module rsps_back import rsps_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  t_q_stat     i_qst,
    output logic        o_pop,
    input  t_cfg        i_cfg,
    rsps_out_if.source  o_res
);

    localparam int B       = SINE_TABLE_BITS;
    localparam int QUARTER = 1 << (B - 2);
    localparam logic [B-1:0] QTR_IDX = B'(QUARTER);
    localparam logic [B-2:0] QTR_J   = (B - 1)'(QUARTER);

    logic [14:0] w_qsin [2*QUARTER];

    for (genvar g = 0; g < 2 * QUARTER; g++) begin : g_tab
        assign w_qsin[g] = quarter_sine(g, B);
    end

    logic               w_adv;
    logic [B-1:0]       w_ia [2];
    logic [B-2:0]       w_j  [2];
    logic [1:0]         w_q  [2];
    logic signed [15:0] w_trig [2];

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_item r_m1, r_m2, r_m3, r_m4;

    logic signed [15:0] r_s, r_c;
    logic signed [30:0] r_xl, r_yl;
    logic signed [62:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [27:0] r_vx, r_vy;

    logic signed [20:0] w_r;
    logic signed [36:0] w_rc, w_rs;
    logic signed [63:0] w_sx, w_sy;
    logic signed [28:0] w_ox, w_oy;
    logic signed [23:0] w_satx, w_saty;

    logic               r_pv;
    logic signed [23:0] r_px, r_py;
    logic [11:0]        r_pidx, r_sidx;
    logic               r_sst, r_last;
    logic [12:0]        r_tot;

    assign w_adv = !r_v5 || o_res.ready;
    assign o_pop = w_adv && !i_qst.empty;

    // quarter-wave symmetry on both lookups
    always_comb begin
        w_ia[0] = i_item.az[15 -: B];
        w_ia[1] = i_item.az[15 -: B] + QTR_IDX;
        for (int k = 0; k < 2; k++) begin
            w_q[k] = w_ia[k][B-1:B-2];
            w_j[k] = {1'b0, w_ia[k][B-3:0]};
            if (w_q[k][0]) begin
                w_j[k] = QTR_J - w_j[k];
            end
            w_trig[k] = w_q[k][1] ? -$signed({1'b0, w_qsin[w_j[k]]})
                                  :  $signed({1'b0, w_qsin[w_j[k]]});
        end
    end

    assign w_r  = $signed({1'b0, r_m1.range});
    assign w_rc = 37'(w_r) * 37'(r_c) + 37'sd32;
    assign w_rs = 37'(w_r) * 37'(r_s) + 37'sd32;

    assign w_sx = 64'(r_pa) + 64'(r_pb) + 64'sh8_0000_0000;
    assign w_sy = 64'(r_pc) + 64'(r_pd) + 64'sh8_0000_0000;

    assign w_ox = 29'(r_vx) + 29'(i_cfg.off_x);
    assign w_oy = 29'(r_vy) + 29'(i_cfg.off_y);

    always_comb begin
        if (w_ox > 29'sd8388607) begin
            w_satx = 24'sh7FFFFF;
        end else if (w_ox < -29'sd8388608) begin
            w_satx = -24'sh800000;
        end else begin
            w_satx = w_ox[23:0];
        end
        if (w_oy > 29'sd8388607) begin
            w_saty = 24'sh7FFFFF;
        end else if (w_oy < -29'sd8388608) begin
            w_saty = -24'sh800000;
        end else begin
            w_saty = w_oy[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1 <= i_item;
            r_s  <= w_trig[0];
            r_c  <= w_trig[1];
            r_m2 <= r_m1;
            r_xl <= w_rc[36:6];
            r_yl <= w_rs[36:6];
            r_m3 <= r_m2;
            r_pa <= 63'($signed(i_cfg.row_x[31:0]))  * 63'(r_xl);
            r_pb <= 63'($signed(i_cfg.row_x[63:32])) * 63'(r_yl);
            r_pc <= 63'($signed(i_cfg.row_y[31:0]))  * 63'(r_xl);
            r_pd <= 63'($signed(i_cfg.row_y[63:32])) * 63'(r_yl);
            r_m4 <= r_m3;
            r_vx <= w_sx[63:36];
            r_vy <= w_sy[63:36];
            r_pv   <= r_m4.pvalid;
            r_px   <= r_m4.pvalid ? w_satx : 24'sd0;
            r_py   <= r_m4.pvalid ? w_saty : 24'sd0;
            r_pidx <= r_m4.pidx;
            r_sidx <= r_m4.sidx;
            r_sst  <= r_m4.sstart;
            r_last <= r_m4.last;
            r_tot  <= r_m4.total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= !i_qst.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign o_res.valid         = r_v5;
    assign o_res.point_valid   = r_pv;
    assign o_res.point_x       = r_px;
    assign o_res.point_y       = r_py;
    assign o_res.point_index   = r_pidx;
    assign o_res.segment_start = r_sst;
    assign o_res.segment_index = r_sidx;
    assign o_res.scan_done     = r_last;
    assign o_res.point_total   = r_tot;

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && !o_res.ready) |=> (r_v4 == $past(r_v4) && r_v1 == $past(r_v1)))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// ===== sv/range_scan_to_points_segmenter.sv =====
// ----------------------------------------------------------------------------
// range_scan_to_points_segmenter: lidar range samples to segmented points
// Usage:
//   i_in   sample channel (range_mm, range_bad, scan_last), valid/ready.
//   o_res  one result per sample: point flag, saturated x/y in mm, point
//          and segment numbers, scan_done and running point total.
//   i_cfg  register writes (index 0..7, 64-bit data), always ready; write
//          only while no sample is in flight.
// Intake sequencer: one sample at a time, through capture, jump-threshold
//   partial products, classify and queue; ready stays low meanwhile.
// Structure: intake and the 5-stage transform pipeline are split by
//   a 4-entry queue.
// Reset: synchronous active-low; registers take their defaults, scan
//   state clears, queue and pipeline empty.
// Output stall: the transform pipeline freezes; intake takes samples
//   until the queue is full and one more waits, then holds ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module range_scan_to_points_segmenter import rsps_pkg::*; #(
    parameter int MAX_POINTS      = MAX_POINTS_DEF,
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsps_in_if.sink    i_in,
    rsps_out_if.source o_res,
    rsps_cfg_if.sink   i_cfg
);

    t_cfg    r_cfg;
    t_item   w_push_item, w_pop_item;
    t_q_stat w_qst;
    logic    w_push, w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min  <= 20'd0;
            r_cfg.range_max  <= 20'hFFFFF;
            r_cfg.angle_min  <= 16'd0;
            r_cfg.angle_step <= 16'd0;
            r_cfg.row_x      <= 64'h0000_0000_1000_0000;
            r_cfg.row_y      <= 64'h1000_0000_0000_0000;
            r_cfg.off_x      <= 21'sd0;
            r_cfg.off_y      <= 21'sd0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RANGE_MIN:  r_cfg.range_min  <= i_cfg.data[19:0];
                REG_RANGE_MAX:  r_cfg.range_max  <= i_cfg.data[19:0];
                REG_ANGLE_MIN:  r_cfg.angle_min  <= i_cfg.data[15:0];
                REG_ANGLE_STEP: r_cfg.angle_step <= i_cfg.data[15:0];
                REG_ROW_X:      r_cfg.row_x      <= i_cfg.data;
                REG_ROW_Y:      r_cfg.row_y      <= i_cfg.data;
                REG_OFFSET_X:   r_cfg.off_x      <= $signed(i_cfg.data[20:0]);
                REG_OFFSET_Y:   r_cfg.off_y      <= $signed(i_cfg.data[20:0]);
                default: ;
            endcase
        end
    end

    rsps_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_qst   (w_qst),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    rsps_queue #(.DEPTH(QUEUE_DEPTH_DEF)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_stat  (w_qst)
    );

    rsps_back #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_pop_item),
        .i_qst   (w_qst),
        .o_pop   (w_pop),
        .i_cfg   (r_cfg),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
